/* rtl/sha256_digest_engine_defines.svh */
// ----------------------------------------------------------------------------
// SHA-256 digest engine assertion macros
// Shared concurrent assertion forms, clocked and reset-qualified.
// ----------------------------------------------------------------------------
`ifndef SHA256_DIGEST_ENGINE_DEFINES_SVH
`define SHA256_DIGEST_ENGINE_DEFINES_SVH

// same-cycle implication
`define SDE_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define SDE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/sde_pkg.sv */
// ----------------------------------------------------------------------------
// SHA-256 digest engine package
// Transaction types, queue entry type and the SHA-256 constants.
// ----------------------------------------------------------------------------
package sde_pkg;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       byte_present;
		logic       message_end;
	} byte_item_t;

	typedef struct packed {
		logic [31:0] digest_word;
		logic [2:0]  word_number;
		logic        final_word;
	} digest_item_t;

	// one big-endian message word on its way to the compressor
	typedef struct packed {
		logic [31:0] word;
		logic        msg_last;
	} sched_entry_t;

	localparam int unsigned BLOCK_WORDS = 16;
	localparam int unsigned ROUNDS      = 64;
	localparam int unsigned HASH_WORDS  = 8;
	localparam logic [7:0]  PAD_BYTE    = 8'h80;
	localparam logic [3:0]  LEN_HI_IDX  = 4'd14;

	localparam logic [31:0] INIT_HASH [HASH_WORDS] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [31:0] ROUND_K [ROUNDS] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

endpackage

/* rtl/sde_front.sv */
// ----------------------------------------------------------------------------
// SHA-256 front end
// Packs message bytes into big-endian words and appends the padding words.
// ----------------------------------------------------------------------------
module sde_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 byte_valid,
	output logic                 byte_ready,
	input  sde_pkg::byte_item_t  byte_item,
	output logic                 push_valid,
	input  logic                 push_ready,
	output sde_pkg::sched_entry_t push_entry
);
	import sde_pkg::*;

	localparam logic [1:0] F_BYTES  = 2'd0;
	localparam logic [1:0] F_PAD    = 2'd1;
	localparam logic [1:0] F_ZERO   = 2'd2;
	localparam logic [1:0] F_LEN_LO = 2'd3;

	logic [1:0]  fstate_q;
	logic [60:0] byte_cnt_q;
	logic [31:0] pack_q;
	logic [3:0]  widx_q;

	logic        accept;
	logic [1:0]  off;
	logic [4:0]  lane_shift;
	logic [31:0] ins_word;
	logic [31:0] pad_word;
	logic [63:0] bit_len;

	assign off        = byte_cnt_q[1:0];
	assign lane_shift = {~off, 3'b000};
	assign ins_word   = pack_q | ({24'b0, byte_item.data_byte} << lane_shift);
	assign pad_word   = pack_q | ({24'b0, PAD_BYTE} << lane_shift);
	assign bit_len    = {byte_cnt_q, 3'b000};

	assign byte_ready = (fstate_q == F_BYTES) && push_ready;
	assign accept     = byte_valid && byte_ready;

	always_comb begin
		push_valid          = 1'b0;
		push_entry.word     = 32'h0;
		push_entry.msg_last = 1'b0;
		unique case (fstate_q)
			F_BYTES: begin
				push_valid      = accept && byte_item.byte_present && (off == 2'd3);
				push_entry.word = ins_word;
			end
			F_PAD: begin
				push_valid      = 1'b1;
				push_entry.word = pad_word;
			end
			F_ZERO: begin
				push_valid      = 1'b1;
				push_entry.word = (widx_q == LEN_HI_IDX) ? bit_len[63:32] : 32'h0;
			end
			F_LEN_LO: begin
				push_valid          = 1'b1;
				push_entry.word     = bit_len[31:0];
				push_entry.msg_last = 1'b1;
			end
			default: begin
				push_valid = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fstate_q   <= F_BYTES;
			byte_cnt_q <= '0;
			pack_q     <= '0;
			widx_q     <= '0;
		end else begin
			unique case (fstate_q)
				F_BYTES: begin
					if (accept) begin
						if (byte_item.byte_present) begin
							byte_cnt_q <= byte_cnt_q + 61'd1;
							pack_q     <= (off == 2'd3) ? 32'h0 : ins_word;
						end
						if (byte_item.message_end)
							fstate_q <= F_PAD;
					end
				end
				F_PAD: begin
					if (push_ready) begin
						widx_q   <= byte_cnt_q[5:2] + 4'd1;
						pack_q   <= 32'h0;
						fstate_q <= F_ZERO;
					end
				end
				F_ZERO: begin
					if (push_ready) begin
						if (widx_q == LEN_HI_IDX)
							fstate_q <= F_LEN_LO;
						else
							widx_q <= widx_q + 4'd1;
					end
				end
				F_LEN_LO: begin
					if (push_ready) begin
						byte_cnt_q <= '0;
						pack_q     <= 32'h0;
						fstate_q   <= F_BYTES;
					end
				end
				default: begin
					fstate_q <= F_BYTES;
				end
			endcase
		end
	end

endmodule

/* rtl/sde_queue.sv */
// ----------------------------------------------------------------------------
// SHA-256 word queue
// Small FIFO of message words between the front end and the compressor.
// ----------------------------------------------------------------------------
module sde_queue #(
	parameter int unsigned DEPTH = 4
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push_valid,
	output logic                  push_ready,
	input  sde_pkg::sched_entry_t push_entry,
	output logic                  pop_valid,
	input  logic                  pop_ready,
	output sde_pkg::sched_entry_t pop_entry
);
	import sde_pkg::*;

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	sched_entry_t        entries_q [DEPTH];
	logic [PTR_W-1:0]    wr_ptr_q;
	logic [PTR_W-1:0]    rd_ptr_q;
	logic [CNT_W-1:0]    count_q;
	logic                do_push;
	logic                do_pop;

	assign push_ready = (count_q != CNT_W'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_entry  = entries_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (do_push)
			entries_q[wr_ptr_q] <= push_entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			if (do_push && !do_pop)
				count_q <= count_q + CNT_W'(1);
			else if (do_pop && !do_push)
				count_q <= count_q - CNT_W'(1);
		end
	end

endmodule

/* rtl/sde_core.sv */
// ----------------------------------------------------------------------------
// SHA-256 compression core
// One round per cycle unless waiting for a queue word; schedule word prefetched into a register; digest output.
// ----------------------------------------------------------------------------
module sde_core (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  word_valid,
	output logic                  word_ready,
	input  sde_pkg::sched_entry_t word_entry,
	output logic                  digest_valid,
	input  logic                  digest_ready,
	output sde_pkg::digest_item_t digest_item
);
	import sde_pkg::*;

	localparam logic [1:0] C_RUN = 2'd0;
	localparam logic [1:0] C_FIN = 2'd1;
	localparam logic [1:0] C_OUT = 2'd2;

	function automatic logic [31:0] rotr(input logic [31:0] v, input int unsigned n);
		return (v >> n) | (v << (32 - n));
	endfunction

	logic [1:0]  cstate_q;
	logic [6:0]  cnt_q;
	logic        last_q;
	logic [2:0]  oidx_q;
	logic [31:0] chain_q [HASH_WORDS];
	logic [31:0] vars_q  [HASH_WORDS];
	logic [31:0] w_q     [BLOCK_WORDS];
	logic [31:0] wk_s1;
	digest_item_t out_q;
	logic        out_valid_q;

	logic        loading;
	logic        advance;
	logic        out_load;
	logic [31:0] w_new;
	logic [31:0] sig0, sig1;
	logic [31:0] s0, s1, chf, maj, t1, t2;

	assign loading    = (cstate_q == C_RUN) && (cnt_q < 7'd16);
	assign word_ready = loading;
	assign advance    = (cstate_q == C_RUN) && (!loading || word_valid);
	assign out_load   = (cstate_q == C_OUT) && (!out_valid_q || digest_ready);

	// schedule: w_q[15] is the newest word
	assign sig0  = rotr(w_q[1], 7) ^ rotr(w_q[1], 18) ^ (w_q[1] >> 3);
	assign sig1  = rotr(w_q[14], 17) ^ rotr(w_q[14], 19) ^ (w_q[14] >> 10);
	assign w_new = loading ? word_entry.word : (w_q[0] + sig0 + w_q[9] + sig1);

	// round
	assign s1  = rotr(vars_q[4], 6) ^ rotr(vars_q[4], 11) ^ rotr(vars_q[4], 25);
	assign chf = (vars_q[4] & vars_q[5]) ^ (~vars_q[4] & vars_q[6]);
	assign s0  = rotr(vars_q[0], 2) ^ rotr(vars_q[0], 13) ^ rotr(vars_q[0], 22);
	assign maj = (vars_q[0] & vars_q[1]) ^ (vars_q[0] & vars_q[2]) ^
	             (vars_q[1] & vars_q[2]);
	assign t1  = vars_q[7] + s1 + chf + wk_s1;
	assign t2  = s0 + maj;

	assign digest_valid = out_valid_q;
	assign digest_item  = out_q;

	always_ff @(posedge clk) begin
		if (advance && (cnt_q < 7'd64)) begin
			for (int i = 0; i < BLOCK_WORDS - 1; i++)
				w_q[i] <= w_q[i+1];
			w_q[BLOCK_WORDS-1] <= w_new;
			wk_s1 <= w_new + ROUND_K[cnt_q[5:0]];
		end
		if (out_load) begin
			out_q.digest_word <= chain_q[oidx_q];
			out_q.word_number <= oidx_q;
			out_q.final_word  <= (oidx_q == 3'd7);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cstate_q    <= C_RUN;
			cnt_q       <= '0;
			last_q      <= 1'b0;
			oidx_q      <= '0;
			out_valid_q <= 1'b0;
			for (int k = 0; k < HASH_WORDS; k++) begin
				chain_q[k] <= INIT_HASH[k];
				vars_q[k]  <= INIT_HASH[k];
			end
		end else begin
			if (out_load)
				out_valid_q <= 1'b1;
			else if (digest_ready)
				out_valid_q <= 1'b0;

			unique case (cstate_q)
				C_RUN: begin
					if (advance) begin
						// round cnt-1 runs on the word prefetched at the previous advance
						if (cnt_q != 7'd0) begin
							vars_q[7] <= vars_q[6];
							vars_q[6] <= vars_q[5];
							vars_q[5] <= vars_q[4];
							vars_q[4] <= vars_q[3] + t1;
							vars_q[3] <= vars_q[2];
							vars_q[2] <= vars_q[1];
							vars_q[1] <= vars_q[0];
							vars_q[0] <= t1 + t2;
						end
						if (cnt_q == 7'd15)
							last_q <= word_entry.msg_last;
						if (cnt_q == 7'd64) begin
							cnt_q    <= '0;
							cstate_q <= C_FIN;
						end else begin
							cnt_q <= cnt_q + 7'd1;
						end
					end
				end
				C_FIN: begin
					for (int k = 0; k < HASH_WORDS; k++) begin
						chain_q[k] <= chain_q[k] + vars_q[k];
						vars_q[k]  <= chain_q[k] + vars_q[k];
					end
					oidx_q   <= '0;
					cstate_q <= last_q ? C_OUT : C_RUN;
				end
				C_OUT: begin
					if (out_load) begin
						if (oidx_q == 3'd7) begin
							for (int k = 0; k < HASH_WORDS; k++) begin
								chain_q[k] <= INIT_HASH[k];
								vars_q[k]  <= INIT_HASH[k];
							end
							cstate_q <= C_RUN;
						end else begin
							oidx_q <= oidx_q + 3'd1;
						end
					end
				end
				default: begin
					cstate_q <= C_RUN;
				end
			endcase
		end
	end

endmodule

/* rtl/sha256_digest_engine.sv */
// ----------------------------------------------------------------------------
// SHA-256 digest engine
// Byte-stream SHA-256: front end packs and pads, core compresses and emits.
// ----------------------------------------------------------------------------
// Usage:
//   byte channel: one transaction per message byte (byte_present = 1), the
//   last one with message_end = 1. A transaction with byte_present = 0 and
//   message_end = 1 closes a message without a byte (empty message possible).
//   digest channel: eight transactions per message, word_number 0..7, the
//   most significant word first, final_word set on word 7.
//   Bytes are taken one per cycle while the word queue has room and the
//   front end is not emitting padding. Per 64-byte block the core runs 16
//   loading rounds fed from the queue, 48 more rounds, one prefetch step
//   and one chaining add, but only the queued words (four by default)
//   overlap its rounds, so a long message stalls the byte channel while
//   the core runs the remaining rounds and the chaining add. After
//   message_end the front end emits up to 18 padding words, one per cycle
//   while the queue has room; the digest words leave the output register
//   after the final chaining add, one per cycle while the receiver is ready.
//   A stalled digest receiver holds the output register; the front end keeps
//   filling the queue and stops taking bytes when it is full.
//   Reset loads the initial hash values and empties the queue and counters.
// ----------------------------------------------------------------------------
module sha256_digest_engine #(
	parameter int unsigned QUEUE_DEPTH = 4
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  byte_valid,
	output logic                  byte_ready,
	input  sde_pkg::byte_item_t   byte_item,
	output logic                  digest_valid,
	input  logic                  digest_ready,
	output sde_pkg::digest_item_t digest_item
);
	import sde_pkg::*;

	logic         push_valid;
	logic         push_ready;
	sched_entry_t push_entry;
	logic         pop_valid;
	logic         pop_ready;
	sched_entry_t pop_entry;

	sde_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_ready (byte_ready),
		.byte_item  (byte_item),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_entry (push_entry)
	);

	sde_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_entry (push_entry),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_entry  (pop_entry)
	);

	sde_core u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.word_valid   (pop_valid),
		.word_ready   (pop_ready),
		.word_entry   (pop_entry),
		.digest_valid (digest_valid),
		.digest_ready (digest_ready),
		.digest_item  (digest_item)
	);

endmodule

/* rtl/sde_checker.sv */
// ----------------------------------------------------------------------------
// SHA-256 digest engine checker
// Port-level checks on the digest channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "sha256_digest_engine_defines.svh"

module sde_checker (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  digest_valid,
	input logic                  digest_ready,
	input sde_pkg::digest_item_t digest_item
);
	import sde_pkg::*;

	// stalled transaction holds
	`SDE_ASSERT_NEXT(a_out_hold, clk, arst_n, digest_valid && !digest_ready, digest_valid && $stable(digest_item), "digest stalled transaction changed")

	// words of one digest follow back to back in order
	`SDE_ASSERT_NEXT(a_word_seq, clk, arst_n, digest_valid && digest_ready && !digest_item.final_word, digest_valid && (digest_item.word_number == $past(digest_item.word_number) + 3'd1), "digest word out of sequence")

	// final flag sits on word 7 only
	`SDE_ASSERT_SAME(a_final_pos, clk, arst_n, digest_valid, digest_item.final_word == (digest_item.word_number == 3'd7), "final flag on wrong word")

	// whatever follows the last word starts a new digest at word 0
	`SDE_ASSERT_NEXT(a_gap_after, clk, arst_n, digest_valid && digest_ready && digest_item.final_word, !digest_valid || (digest_item.word_number == 3'd0), "digest after final word does not start at word 0")

endmodule

bind sha256_digest_engine sde_checker u_sde_checker (.*);

/* tb/sha256_digest_checker.sv */
// ----------------------------------------------------------------------------
// SHA-256 digest engine checker
// Watches the byte and digest channels, keeps its own SHA-256 state per
// message, queues the eight digest words expected on each message end and
// compares every accepted digest transaction with the oldest one waiting.
// ----------------------------------------------------------------------------
module sha256_digest_checker (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  byte_valid,
	input  logic                  byte_ready,
	input  sde_pkg::byte_item_t   byte_item,
	input  logic                  digest_valid,
	input  logic                  digest_ready,
	input  sde_pkg::digest_item_t digest_item,
	output int                    fail_count,
	output int                    pending
);
	import sde_pkg::*;

	logic [31:0]  chain [HASH_WORDS];
	logic [7:0]   blk [64];
	int unsigned  fill;
	logic [63:0]  bit_total;
	digest_item_t digest_q [$];

	function automatic logic [31:0] ror32(input logic [31:0] v, input int unsigned n);
		return (v >> n) | (v << (32 - n));
	endfunction

	task automatic report_mismatch(input string msg);
		$display("ERROR: %0t: %s", $time, msg);
		fail_count++;
	endtask

	task automatic restart_message();
		chain = INIT_HASH;
		fill = 0;
		bit_total = '0;
	endtask

	// append one byte; a full block is folded into the chaining value
	task automatic take_byte(input logic [7:0] b);
		logic [31:0] sched [ROUNDS];
		logic [31:0] wv [HASH_WORDS];
		logic [31:0] s0, s1, t1, t2;
		blk[fill] = b;
		fill++;
		if (fill == 64) begin
			for (int t = 0; t < BLOCK_WORDS; t++)
				sched[t] = {blk[4*t], blk[4*t+1], blk[4*t+2], blk[4*t+3]};
			for (int t = BLOCK_WORDS; t < ROUNDS; t++)
				sched[t] = sched[t-16] + sched[t-7]
					+ (ror32(sched[t-15], 7) ^ ror32(sched[t-15], 18) ^ (sched[t-15] >> 3))
					+ (ror32(sched[t-2], 17) ^ ror32(sched[t-2], 19) ^ (sched[t-2] >> 10));
			wv = chain;
			for (int t = 0; t < ROUNDS; t++) begin
				s1 = ror32(wv[4], 6) ^ ror32(wv[4], 11) ^ ror32(wv[4], 25);
				t1 = wv[7] + s1 + ((wv[4] & wv[5]) ^ (~wv[4] & wv[6])) + ROUND_K[t] + sched[t];
				s0 = ror32(wv[0], 2) ^ ror32(wv[0], 13) ^ ror32(wv[0], 22);
				t2 = s0 + ((wv[0] & wv[1]) ^ (wv[0] & wv[2]) ^ (wv[1] & wv[2]));
				wv[7] = wv[6];
				wv[6] = wv[5];
				wv[5] = wv[4];
				wv[4] = wv[3] + t1;
				wv[3] = wv[2];
				wv[2] = wv[1];
				wv[1] = wv[0];
				wv[0] = t1 + t2;
			end
			for (int k = 0; k < HASH_WORDS; k++)
				chain[k] = chain[k] + wv[k];
			fill = 0;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		digest_item_t want;
		logic [63:0]  len_bits;
		if (!arst_n) begin
			restart_message();
			digest_q.delete();
			fail_count = 0;
			pending <= 0;
		end else begin
			// digest side first: anything expected now was queued on an earlier edge
			if (digest_valid && digest_ready) begin
				if (digest_q.size() == 0) begin
					report_mismatch($sformatf("digest word %h (number %0d) with none expected",
						digest_item.digest_word, digest_item.word_number));
				end else begin
					want = digest_q.pop_front();
					if (digest_item.digest_word !== want.digest_word)
						report_mismatch($sformatf("digest_word got %h want %h (number %0d)",
							digest_item.digest_word, want.digest_word, want.word_number));
					if (digest_item.word_number !== want.word_number)
						report_mismatch($sformatf("word_number got %0d want %0d",
							digest_item.word_number, want.word_number));
					if (digest_item.final_word !== want.final_word)
						report_mismatch($sformatf("final_word got %b want %b (number %0d)",
							digest_item.final_word, want.final_word, want.word_number));
				end
			end
			if (byte_valid && byte_ready) begin
				if (byte_item.byte_present) begin
					take_byte(byte_item.data_byte);
					bit_total = bit_total + 64'd8;
				end
				if (byte_item.message_end) begin
					len_bits = bit_total;
					take_byte(PAD_BYTE);
					// no room for the length: zero out this block and use one more
					if (fill > 56)
						while (fill != 0)
							take_byte(8'h00);
					while (fill < 56)
						take_byte(8'h00);
					for (int k = 0; k < 8; k++)
						take_byte(len_bits[63 - 8*k -: 8]);
					for (int k = 0; k < HASH_WORDS; k++) begin
						want.digest_word = chain[k];
						want.word_number = 3'(k);
						want.final_word  = (k == HASH_WORDS - 1);
						digest_q = {digest_q, want};
					end
					restart_message();
				end
			end
			pending <= digest_q.size();
		end
	end

endmodule

/* tb/sha256_digest_engine_tb.sv */
// ----------------------------------------------------------------------------
// SHA-256 digest engine testbench
// Feeds byte messages (directed corner cases, then random ones around the
// padding boundaries and short lengths) with bursty valid and a stalling
// digest receiver; the checker predicts and compares every digest word.
// ----------------------------------------------------------------------------
module sha256_digest_engine_tb;
	import sde_pkg::*;

	localparam int          CLK_HALF     = 6;
	localparam int unsigned STALL_LIMIT  = 3000;
	localparam int unsigned TAIL_CYCLES  = 200;
	localparam int unsigned TOTAL_ITEMS  = 210;
	localparam int unsigned RX_BLOCKED   = 0;
	localparam int unsigned RX_JITTER    = 1;
	localparam int unsigned EDGE_LENGTHS [3] = '{55, 56, 63};

	logic         clk          = 1'b0;
	logic         arst_n       = 1'b0;
	logic         byte_valid   = 1'b0;
	byte_item_t   byte_item    = '0;
	logic         digest_ready = 1'b0;
	logic         byte_ready;
	logic         digest_valid;
	digest_item_t digest_item;
	int           fail_count;
	int           pending;

	int unsigned  burst_left = 0;
	int unsigned  items_sent = 0;
	int unsigned  idle_cycles = 0;
	int unsigned  rx_mode = 0;
	int unsigned  rx_run = 0;

	always #(CLK_HALF) clk = ~clk;

	sha256_digest_engine i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.byte_valid   (byte_valid),
		.byte_ready   (byte_ready),
		.byte_item    (byte_item),
		.digest_valid (digest_valid),
		.digest_ready (digest_ready),
		.digest_item  (digest_item)
	);

	sha256_digest_checker i_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.byte_valid   (byte_valid),
		.byte_ready   (byte_ready),
		.byte_item    (byte_item),
		.digest_valid (digest_valid),
		.digest_ready (digest_ready),
		.digest_item  (digest_item),
		.fail_count   (fail_count),
		.pending      (pending)
	);

	// receiver: runs of blocked, jittery or open cycles
	always @(posedge clk) begin
		if (rx_run == 0) begin
			rx_mode = $urandom_range(0, 3);
			rx_run  = $urandom_range(1, 30);
		end else begin
			rx_run--;
		end
		case (rx_mode)
			RX_BLOCKED: digest_ready <= 1'b0;
			RX_JITTER:  digest_ready <= 1'($urandom_range(0, 1));
			default:    digest_ready <= 1'b1;
		endcase
	end

	always @(posedge clk) begin
		if ((byte_valid && byte_ready) || (digest_valid && digest_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// one byte channel transaction; valid drops only between bursts
	task automatic send_item(input logic [7:0] data, input logic present, input logic last);
		if (burst_left == 0) begin
			byte_valid <= 1'b0;
			repeat ($urandom_range(1, ($urandom_range(0, 4) == 0) ? 40 : 6)) @(posedge clk);
			burst_left = $urandom_range(1, 40);
		end
		byte_valid <= 1'b1;
		byte_item  <= '{data_byte: data, byte_present: present, message_end: last};
		@(posedge clk iff (byte_valid && byte_ready));
		burst_left--;
		if (present || last)
			items_sent++;
	endtask

	// hold the sender until every queued digest word has come out
	task automatic drain_digests();
		byte_valid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	task automatic send_random_message(input int unsigned nbytes);
		logic bare_end;
		bare_end = (nbytes == 0) || ($urandom_range(0, 2) == 0);
		for (int unsigned i = 0; i < nbytes; i++) begin
			if ($urandom_range(0, 11) == 0)
				send_item(8'($urandom), 1'b0, 1'b0);
			send_item(8'($urandom), 1'b1, !bare_end && (i == nbytes - 1));
		end
		if (bare_end)
			send_item(8'($urandom), 1'b0, 1'b1);
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// idle transaction, then the empty message
		send_item(8'hff, 1'b0, 1'b0);
		send_item(8'h00, 1'b0, 1'b1);
		// "abc"
		send_item(8'h61, 1'b1, 1'b0);
		send_item(8'h62, 1'b1, 1'b0);
		send_item(8'h63, 1'b1, 1'b1);
		// single byte carrying the end flag
		send_item(8'h00, 1'b1, 1'b1);
		// single byte closed by a bare end marker
		send_item(8'hff, 1'b1, 1'b0);
		send_item(8'hff, 1'b0, 1'b1);
		send_item(8'h00, 1'b1, 1'b0);
		send_item(8'hff, 1'b1, 1'b0);
		send_item(8'h80, 1'b1, 1'b0);
		send_item(8'h7f, 1'b1, 1'b1);
		drain_digests();

		// padding fits, padding spills into an extra block, pad byte closes a block
		foreach (EDGE_LENGTHS[i])
			send_random_message(EDGE_LENGTHS[i]);
		while (items_sent < TOTAL_ITEMS) begin
			if ($urandom_range(0, 9) == 0)
				drain_digests();
			send_random_message($urandom_range(0, 12));
		end

		byte_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
